@@ rtl/bfta_pkg.sv @@
// ----------------------------------------------------------------------------
// bfta_pkg
// Shared types, constants and helpers of the boundary force/torque block.
// ----------------------------------------------------------------------------
package bfta_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;
  localparam int RATIO_BITS        = 30;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 32;

  localparam logic signed [31:0] BOX_LOW_RST  = 32'sh8000_0000;
  localparam logic signed [31:0] BOX_HIGH_RST = 32'sh7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_X    = 3'd0,
    CFG_LOW_Y    = 3'd1,
    CFG_HIGH_X   = 3'd2,
    CFG_HIGH_Y   = 3'd3,
    CFG_PIVOT_X  = 3'd4,
    CFG_PIVOT_Y  = 3'd5,
    CFG_WEIGHT_X = 3'd6,
    CFG_WEIGHT_Y = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] domain_low_x;
    logic signed [31:0] domain_low_y;
    logic signed [31:0] domain_high_x;
    logic signed [31:0] domain_high_y;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] weight_x;
    logic signed [31:0] weight_y;
  } cfg_t;

  // one queued segment, midpoint offsets already worked out
  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] start_pressure;
    logic signed [31:0] end_pressure;
    logic               body_on_positive_side;
    logic               add_weight;
    logic               last_segment;
    logic signed [34:0] mid_x;
    logic signed [34:0] mid_y;
  } seg_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CHECK,
    BK_DIV,
    BK_MUL,
    BK_INTERP,
    BK_FMUL,
    BK_FSHIFT,
    BK_TQ,
    BK_TQSAT,
    BK_ACC,
    BK_WEIGHT,
    BK_OUT
  } back_state_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

endpackage

@@ rtl/bfta_front.sv @@
// ----------------------------------------------------------------------------
// bfta_front
// Unpacks an input beat and forms the doubled midpoint about the pivot.
// ----------------------------------------------------------------------------
module bfta_front (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [191:0]      s_tdata,
  input  logic [1:0]        s_tuser,
  input  logic              s_tlast,
  input  bfta_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              q_push,
  output bfta_pkg::seg_t    q_din
);
  import bfta_pkg::*;

  logic signed [31:0] sx, sy, ex, ey;

  assign sx = s_tdata[31:0];
  assign sy = s_tdata[63:32];
  assign ex = s_tdata[95:64];
  assign ey = s_tdata[127:96];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_din.start_x               = sx;
    q_din.start_y               = sy;
    q_din.end_x                 = ex;
    q_din.end_y                 = ey;
    q_din.start_pressure        = s_tdata[159:128];
    q_din.end_pressure          = s_tdata[191:160];
    q_din.body_on_positive_side = s_tuser[0];
    q_din.add_weight            = s_tuser[1];
    q_din.last_segment          = s_tlast;
    // start + end - 2 * pivot
    q_din.mid_x = 35'(sx) + 35'(ex) - (35'(cfg.pivot_x) <<< 1);
    q_din.mid_y = 35'(sy) + 35'(ey) - (35'(cfg.pivot_y) <<< 1);
  end

endmodule

@@ rtl/bfta_fifo.sv @@
// ----------------------------------------------------------------------------
// bfta_fifo
// Short queue of classified segments between front and back.
// ----------------------------------------------------------------------------
module bfta_fifo #(
  parameter int DEPTH = bfta_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bfta_pkg::seg_t din,
  output logic           full,
  input  logic           pop,
  output bfta_pkg::seg_t dout,
  output logic           valid
);
  import bfta_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  seg_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/bfta_div.sv @@
// ----------------------------------------------------------------------------
// bfta_div
// Restoring divider for the clip ratio, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfta_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [32:0]                     dividend,
  input  logic [32:0]                     divisor,
  output logic                            busy,
  output logic                            done,
  output logic [bfta_pkg::RATIO_BITS-1:0] quotient
);
  import bfta_pkg::*;

  localparam int NW = $clog2(RATIO_BITS + 1);

  logic [32:0]   rem;
  logic [32:0]   dvs;
  logic [NW-1:0] cnt;
  logic [33:0]   rs;
  logic          ge;

  assign rs = {rem, 1'b0};
  assign ge = rs >= {1'b0, dvs};

  // dividend below divisor, so every partial remainder fits 33 bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? 33'(rs - {1'b0, dvs}) : rs[32:0];
      quotient <= {quotient[RATIO_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= NW'(RATIO_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/bfta_back.sv @@
// ----------------------------------------------------------------------------
// bfta_back
// Clips a segment to the box, forms force and torque, keeps saturating sums
// and holds the result beat.
// ----------------------------------------------------------------------------
module bfta_back #(
  parameter int FRACTION_BITS = bfta_pkg::FRACTION_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  bfta_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  bfta_pkg::seg_t q_dout,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [191:0]   m_tdata
);
  import bfta_pkg::*;

  localparam int SH = FRACTION_BITS + 1;
  localparam logic signed [99:0] TQ_MAX = 100'(64'sh7FFF_FFFF_FFFF_FFFF);
  localparam logic signed [99:0] TQ_MIN = 100'(64'sh8000_0000_0000_0000);
  localparam logic [RATIO_BITS:0] RATIO_ONE = (RATIO_BITS + 1)'(1) << RATIO_BITS;

  back_state_t state, state_next;

  logic signed [31:0] c1x, c1y, c2x, c2y, p1, p2;
  logic               pos, addw, last;
  logic signed [34:0] mx, my;
  logic [2:0]         chk;
  logic signed [31:0] bnd, ybase, pbase;
  logic signed [32:0] dy, dp;
  logic [RATIO_BITS:0] ratio;
  logic [63:0]        prod_y, prod_p;
  logic signed [65:0] prod_fx, prod_fy;
  logic signed [63:0] fx, fy, tq;
  logic [2:0]         tq_step;
  logic signed [67:0] pprod;
  logic               pprod_neg, pprod_hi;
  logic signed [99:0] acc;
  logic signed [63:0] sum_fx, sum_fy, sum_tq;
  logic signed [63:0] out_fx, out_fy, out_tq;

  // clip check
  logic               ax_i, hiside, pt;
  logic signed [31:0] x1, x2, y1, y2, lo_v, hi_v, b, cm, co;
  logic               hit_m, hit_o;
  logic signed [32:0] d, t;
  logic [32:0]        ud, ut;
  logic               ratio_zero, ratio_full;
  logic               div_start, div_busy, div_done;
  logic [RATIO_BITS-1:0] div_q;
  logic               out_load;

  // interpolation
  logic [32:0]        mag_dy, mag_dp;
  logic [33:0]        inc_y, inc_p, ny, np;

  // force and torque operands
  logic signed [32:0] psum, ax, ay;
  logic signed [34:0] op_m;
  logic signed [63:0] op_f;
  logic signed [32:0] part;
  logic signed [99:0] addend, shr;

  always_comb begin
    ax_i   = chk[1];
    hiside = chk[0];
    pt     = chk[2];
    x1     = ax_i ? c1y : c1x;
    x2     = ax_i ? c2y : c2x;
    y1     = ax_i ? c1x : c1y;
    y2     = ax_i ? c2x : c2y;
    lo_v   = ax_i ? cfg.domain_low_y : cfg.domain_low_x;
    hi_v   = ax_i ? cfg.domain_high_y : cfg.domain_high_x;
    b      = hiside ? hi_v : lo_v;
    cm     = pt ? x2 : x1;
    co     = pt ? x1 : x2;
    hit_m  = hiside ? (cm >= b) : (cm <= b);
    hit_o  = hiside ? (co >= b) : (co <= b);
    d      = 33'(x2) - 33'(x1);
    t      = 33'(b) - 33'(x1);
    ud     = d[32] ? 33'(-d) : 33'(d);
    ut     = t[32] ? 33'(-t) : 33'(t);
    ratio_zero = (d == '0) || ((t != '0) && (t[32] != d[32]));
    ratio_full = ut >= ud;

    mag_dy = dy[32] ? 33'(-dy) : 33'(dy);
    mag_dp = dp[32] ? 33'(-dp) : 33'(dp);
    inc_y  = prod_y[63:RATIO_BITS];
    inc_p  = prod_p[63:RATIO_BITS];
    ny     = dy[32] ? 34'(ybase) - inc_y : 34'(ybase) + inc_y;
    np     = dp[32] ? 34'(pbase) - inc_p : 34'(pbase) + inc_p;

    psum = 33'(p1) + 33'(p2);
    ax   = pos ? 33'(c1y) - 33'(c2y) : 33'(c2y) - 33'(c1y);
    ay   = pos ? 33'(c2x) - 33'(c1x) : 33'(c1x) - 33'(c2x);

    // mx*fy - my*fx in four partial products, force split in 32-bit halves
    op_m   = tq_step[1] ? my : mx;
    op_f   = tq_step[1] ? fx : fy;
    part   = tq_step[0] ? {op_f[63], op_f[63:32]} : {1'b0, op_f[31:0]};
    addend = pprod_hi ? (100'(pprod) <<< 32) : 100'(pprod);
    shr    = acc >>> SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = BK_CHECK;
        end
      end
      BK_CHECK: begin
        priority if (!hit_m) begin
          state_next = (chk == 3'd7) ? BK_FMUL : BK_CHECK;
        end else if (hit_o) begin
          state_next = last ? BK_WEIGHT : BK_IDLE;
        end else if (ratio_zero || ratio_full) begin
          state_next = BK_MUL;
        end else begin
          div_start  = 1'b1;
          state_next = BK_DIV;
        end
      end
      BK_DIV:    state_next = div_done ? BK_MUL : BK_DIV;
      BK_MUL:    state_next = BK_INTERP;
      BK_INTERP: state_next = (chk == 3'd7) ? BK_FMUL : BK_CHECK;
      BK_FMUL:   state_next = BK_FSHIFT;
      BK_FSHIFT: state_next = BK_TQ;
      BK_TQ:     state_next = (tq_step == 3'd4) ? BK_TQSAT : BK_TQ;
      BK_TQSAT:  state_next = BK_ACC;
      BK_ACC:    state_next = last ? BK_WEIGHT : BK_IDLE;
      BK_WEIGHT: state_next = BK_OUT;
      BK_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default:   state_next = BK_IDLE;
    endcase
  end

  bfta_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ut),
    .divisor  (ud),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // segment datapath
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          c1x  <= q_dout.start_x;
          c1y  <= q_dout.start_y;
          c2x  <= q_dout.end_x;
          c2y  <= q_dout.end_y;
          p1   <= q_dout.start_pressure;
          p2   <= q_dout.end_pressure;
          pos  <= q_dout.body_on_positive_side;
          addw <= q_dout.add_weight;
          last <= q_dout.last_segment;
          mx   <= q_dout.mid_x;
          my   <= q_dout.mid_y;
          chk  <= '0;
        end
      end
      BK_CHECK: begin
        if (!hit_m) begin
          chk <= chk + 1'b1;
        end else begin
          bnd   <= b;
          ybase <= y1;
          pbase <= p1;
          dy    <= 33'(y2) - 33'(y1);
          dp    <= 33'(p2) - 33'(p1);
          if (ratio_zero) begin
            ratio <= '0;
          end else if (ratio_full) begin
            ratio <= RATIO_ONE;
          end
        end
      end
      BK_DIV: begin
        if (div_done) begin
          ratio <= {1'b0, div_q};
        end
      end
      BK_MUL: begin
        prod_y <= mag_dy * ratio;
        prod_p <= mag_dp * ratio;
      end
      BK_INTERP: begin
        unique case ({pt, ax_i})
          2'b00: begin c1x <= bnd; c1y <= ny[31:0]; p1 <= np[31:0]; end
          2'b01: begin c1y <= bnd; c1x <= ny[31:0]; p1 <= np[31:0]; end
          2'b10: begin c2x <= bnd; c2y <= ny[31:0]; p2 <= np[31:0]; end
          2'b11: begin c2y <= bnd; c2x <= ny[31:0]; p2 <= np[31:0]; end
          default: ;
        endcase
        chk <= chk + 1'b1;
      end
      BK_FMUL: begin
        prod_fx <= 66'(psum) * 66'(ax);
        prod_fy <= 66'(psum) * 66'(ay);
      end
      BK_FSHIFT: begin
        fx      <= 64'(prod_fx >>> SH);
        fy      <= 64'(prod_fy >>> SH);
        acc     <= '0;
        tq_step <= '0;
      end
      BK_TQ: begin
        if (tq_step != 3'd4) begin
          pprod     <= 68'(op_m) * 68'(part);
          pprod_neg <= tq_step[1];
          pprod_hi  <= tq_step[0];
        end
        if (tq_step != 3'd0) begin
          acc <= pprod_neg ? acc - addend : acc + addend;
        end
        tq_step <= tq_step + 1'b1;
      end
      BK_TQSAT: begin
        priority if (shr > TQ_MAX) begin
          tq <= TQ_MAX[63:0];
        end else if (shr < TQ_MIN) begin
          tq <= TQ_MIN[63:0];
        end else begin
          tq <= shr[63:0];
        end
      end
      default: ;
    endcase
  end

  // running sums and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_fx   <= '0;
      sum_fy   <= '0;
      sum_tq   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= out_load || (m_tvalid && !m_tready);
      if (state == BK_ACC) begin
        sum_fx <= sat_add64(sum_fx, fx);
        sum_fy <= sat_add64(sum_fy, fy);
        sum_tq <= sat_add64(sum_tq, tq);
      end
      if (state == BK_WEIGHT && addw) begin
        sum_fx <= sat_add64(sum_fx, 64'(cfg.weight_x));
        sum_fy <= sat_add64(sum_fy, 64'(cfg.weight_y));
      end
      if (out_load) begin
        out_fx   <= sum_fx;
        out_fy   <= sum_fy;
        out_tq   <= sum_tq;
        sum_fx   <= '0;
        sum_fy   <= '0;
        sum_tq   <= '0;
      end
    end
  end

  assign m_tdata = {out_tq, out_fy, out_fx};

  a_div_only_waiting: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV) |-> (div_busy || div_done))
    else $error("waiting on divider that is not running");

  a_beat_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == BK_OUT))
    else $error("result beat raised outside output state");

  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (sum_fx == '0 && sum_fy == '0 && sum_tq == '0))
    else $error("sums not cleared after result");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == BK_IDLE && q_valid))
    else $error("queue popped while busy");

endmodule

@@ rtl/boundary_force_torque_accumulator.sv @@
// ----------------------------------------------------------------------------
// boundary_force_torque_accumulator
// Sums pressure force and torque over clipped boundary segments of a body.
//
//   channel  dir  beat fields (lowest bit first)
//   s_*      in   tdata: start_x start_y end_x end_y start_pressure
//                 end_pressure; tuser: body_on_positive_side add_weight;
//                 tlast: last_segment
//   m_*      out  tdata: force_x force_y torque
//   cfg_*    in   register index, 32-bit data, one write per cycle
//
// In the back end a segment passes the check, force and torque states; each
// endpoint clip runs the 30-step ratio divider, which is not used when the
// ratio is 0 or 1; a skipped segment ends at the check that finds it outside
// the box, and a last segment adds the weight and result states.
// The front takes beats while the segment queue has room, independent of
// the back end; the result register holds one beat while the back end works.
// Synchronous reset clears sums, queue and handshake state and loads the
// register reset values.
// ----------------------------------------------------------------------------
module boundary_force_torque_accumulator #(
  parameter int FRACTION_BITS = bfta_pkg::FRACTION_BITS_DEF,
  parameter int QUEUE_DEPTH   = bfta_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // start_x, start_y, end_x, end_y, start_pressure, end_pressure
  input  logic [191:0]                       s_tdata,
  // body_on_positive_side, add_weight
  input  logic [1:0]                         s_tuser,
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // force_x, force_y, torque
  output logic [191:0]                       m_tdata,
  input  logic                               cfg_we,
  input  logic [bfta_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfta_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bfta_pkg::*;

  cfg_t cfg;
  seg_t q_din, q_dout;
  logic q_push, q_full, q_pop, q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.domain_low_x  <= BOX_LOW_RST;
      cfg.domain_low_y  <= BOX_LOW_RST;
      cfg.domain_high_x <= BOX_HIGH_RST;
      cfg.domain_high_y <= BOX_HIGH_RST;
      cfg.pivot_x       <= '0;
      cfg.pivot_y       <= '0;
      cfg.weight_x      <= '0;
      cfg.weight_y      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LOW_X:    cfg.domain_low_x  <= cfg_wdata;
        CFG_LOW_Y:    cfg.domain_low_y  <= cfg_wdata;
        CFG_HIGH_X:   cfg.domain_high_x <= cfg_wdata;
        CFG_HIGH_Y:   cfg.domain_high_y <= cfg_wdata;
        CFG_PIVOT_X:  cfg.pivot_x       <= cfg_wdata;
        CFG_PIVOT_Y:  cfg.pivot_y       <= cfg_wdata;
        CFG_WEIGHT_X: cfg.weight_x      <= cfg_wdata;
        CFG_WEIGHT_Y: cfg.weight_y      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bfta_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_din    (q_din)
  );

  bfta_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  bfta_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_dout   (q_dout),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
